/* rtl/core/apd_pkg.sv */
package apd_pkg;

   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int STEP_MAX   = 48;
   localparam int LEAK_NUM   = 245;

   typedef logic [PTR_W-1:0] ptr_type;

   localparam logic [7:0] IDLE_STATUS = 8'h80;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [3:0] ADDR_CONTROL = 4'd0;
   localparam logic [3:0] ADDR_DATA    = 4'd1;
   localparam logic [3:0] ADDR_PAN     = 4'd2;

   localparam logic [1:0] REG_MUTE        = 2'd0;
   localparam logic [1:0] REG_ALLOW_10BIT = 2'd1;
   localparam logic [1:0] REG_OUTPUT_12BIT = 2'd2;

   // control byte bit positions
   localparam int CTRL_STOP = 0;
   localparam int CTRL_PLAY = 1;
   localparam int CTRL_REC  = 2;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_CONTROL,
      CMD_DATA,
      CMD_PAN,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic mute;
      logic allow_10bit;
      logic output_12bit;
   } cfg_type;

   // floor(16 * 1.1^idx)
   function automatic logic [10:0] step_size(input logic [5:0] idx);
      logic [10:0] v;
      begin
         case (idx)
            6'd0:  v = 11'd16;   6'd1:  v = 11'd17;   6'd2:  v = 11'd19;
            6'd3:  v = 11'd21;   6'd4:  v = 11'd23;   6'd5:  v = 11'd25;
            6'd6:  v = 11'd28;   6'd7:  v = 11'd31;   6'd8:  v = 11'd34;
            6'd9:  v = 11'd37;   6'd10: v = 11'd41;   6'd11: v = 11'd45;
            6'd12: v = 11'd50;   6'd13: v = 11'd55;   6'd14: v = 11'd60;
            6'd15: v = 11'd66;   6'd16: v = 11'd73;   6'd17: v = 11'd80;
            6'd18: v = 11'd88;   6'd19: v = 11'd97;   6'd20: v = 11'd107;
            6'd21: v = 11'd118;  6'd22: v = 11'd130;  6'd23: v = 11'd143;
            6'd24: v = 11'd157;  6'd25: v = 11'd173;  6'd26: v = 11'd190;
            6'd27: v = 11'd209;  6'd28: v = 11'd230;  6'd29: v = 11'd253;
            6'd30: v = 11'd279;  6'd31: v = 11'd307;  6'd32: v = 11'd337;
            6'd33: v = 11'd371;  6'd34: v = 11'd408;  6'd35: v = 11'd449;
            6'd36: v = 11'd494;  6'd37: v = 11'd544;  6'd38: v = 11'd598;
            6'd39: v = 11'd658;  6'd40: v = 11'd724;  6'd41: v = 11'd796;
            6'd42: v = 11'd876;  6'd43: v = 11'd963;  6'd44: v = 11'd1060;
            6'd45: v = 11'd1166; 6'd46: v = 11'd1282; 6'd47: v = 11'd1411;
            6'd48: v = 11'd1552;
            default: v = 11'd0;
         endcase
         return v;
      end
   endfunction

   function automatic logic signed [4:0] step_adjust(input logic [2:0] mag);
      logic signed [4:0] v;
      begin
         case (mag)
            3'd4:    v = 5'sd2;
            3'd5:    v = 5'sd4;
            3'd6:    v = 5'sd6;
            3'd7:    v = 5'sd8;
            default: v = -5'sd1;
         endcase
         return v;
      end
   endfunction

endpackage

/* rtl/core/apd_if.sv */
interface apd_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [3:0] reg_addr;
   logic [7:0] write_data;

   modport source (output valid, op, reg_addr, write_data, input ready);
   modport sink   (input valid, op, reg_addr, write_data, output ready);
endinterface

interface apd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_sample;
   logic signed [15:0] right_sample;
   logic [7:0]         status_byte;

   modport source (output valid, left_sample, right_sample, status_byte, input ready);
   modport sink   (input valid, left_sample, right_sample, status_byte, output ready);
endinterface

interface apd_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/apd_front.sv */
module apd_front (
   input  logic              clock,
   input  logic              reset,
   apd_req_if.sink           req,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output apd_pkg::cmd_type  cmd
);

   apd_pkg::cmd_type q_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   apd_pkg::cmd_type cls;
   logic             push, pop;

   // classify the request
   always_comb begin
      cls.data = req.write_data;
      if (req.op == apd_pkg::OP_TICK) begin
         cls.kind = apd_pkg::CMD_TICK;
      end else begin
         case (req.reg_addr)
            apd_pkg::ADDR_CONTROL: cls.kind = apd_pkg::CMD_CONTROL;
            apd_pkg::ADDR_DATA:    cls.kind = apd_pkg::CMD_DATA;
            apd_pkg::ADDR_PAN:     cls.kind = apd_pkg::CMD_PAN;
            default:               cls.kind = apd_pkg::CMD_NOP;
         endcase
      end
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

/* rtl/core/apd_back.sv */
module apd_back (
   input  logic              clock,
   input  logic              reset,
   input  apd_pkg::cfg_type  cfg,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  apd_pkg::cmd_type  cmd,
   apd_rsp_if.source         rsp
);

   function automatic apd_pkg::ptr_type ptr_inc(input apd_pkg::ptr_type p);
      return (p == apd_pkg::ptr_type'(apd_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic signed [11:0] sig_ff, sig_in;
   logic [5:0]         step_ff, step_in;
   logic               hnn_ff, hnn_in;
   logic [7:0]         cur_ff, cur_in;
   logic [7:0]         fifo_ff [apd_pkg::FIFO_DEPTH];
   apd_pkg::ptr_type   rp_ff, rp_in;
   apd_pkg::ptr_type   wp_ff, wp_in;
   logic [7:0]         ec_ff, ec_in;
   logic signed [15:0] held_ff, held_in;
   logic [1:0]         pan_ff, pan_in;
   logic               play_ff, play_in;

   logic               rsp_valid_ff;
   logic signed [15:0] left_ff, left_in;
   logic signed [15:0] right_ff, right_in;
   logic [7:0]         status_ff, status_in;

   logic               fifo_we;
   apd_pkg::ptr_type   fifo_wa;
   logic [7:0]         fifo_wd;
   logic               take;

   // working values of a tick
   logic [7:0]         byte_v;
   logic [7:0]         ec_v;
   apd_pkg::ptr_type   rp_v;
   apd_pkg::ptr_type   base_rp, base_wp, wp_adv;
   logic [3:0]         nib;
   logic [10:0]        sv;
   logic [11:0]        dmag;
   logic signed [13:0] dsgn;
   logic signed [21:0] tsum;
   logic signed [13:0] lvl;
   logic signed [13:0] bound_hi, bound_lo;
   logic signed [11:0] dec_sig;
   logic signed [6:0]  st;
   logic signed [15:0] prod, pmag, pq;
   logic signed [15:0] smp;

   assign take      = cmd_valid && (!rsp_valid_ff || rsp.ready);
   assign cmd_ready = !rsp_valid_ff || rsp.ready;

   // decode one nibble against the current state
   always_comb begin
      nib  = 4'd0;
      byte_v = cur_ff;
      ec_v = ec_ff;
      rp_v = rp_ff;
      if (!hnn_ff) begin
         if (ec_ff == 8'd0) begin
            byte_v = fifo_ff[rp_ff];
            rp_v   = ptr_inc(rp_ff);
            if (rp_v == wp_ff) begin
               ec_v = 8'd1;
            end
         end else if (ec_ff < 8'h80) begin
            ec_v = ec_ff + 8'd1;
         end
      end
      nib = hnn_ff ? byte_v[7:4] : byte_v[3:0];

      sv   = apd_pkg::step_size(step_ff);
      dmag = {4'd0, sv[10:3]}
           + (nib[2] ? {1'b0, sv} : 12'd0)
           + (nib[1] ? {2'b0, sv[10:1]} : 12'd0)
           + (nib[0] ? {3'b0, sv[10:2]} : 12'd0);
      dsgn = nib[3] ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
      tsum = $signed({dsgn, 8'd0}) + 22'(sig_ff) * 22'sd245;
      lvl  = tsum[21:8];
      if (cfg.allow_10bit && !cfg.output_12bit) begin
         bound_hi = 14'sd511;
         bound_lo = -14'sd512;
      end else begin
         bound_hi = 14'sd2047;
         bound_lo = -14'sd2048;
      end
      if (lvl > bound_hi) begin
         dec_sig = bound_hi[11:0];
      end else if (lvl < bound_lo) begin
         dec_sig = bound_lo[11:0];
      end else begin
         dec_sig = lvl[11:0];
      end
      st = $signed({1'b0, step_ff}) + 7'(apd_pkg::step_adjust(nib[2:0]));

      // underrun decay: signal * 15 / 16, toward zero
      prod = 16'(sig_ff) * 16'sd15;
      pmag = prod[15] ? -prod : prod;
      pq   = prod[15] ? -(pmag >>> 4) : (pmag >>> 4);
   end

   always_comb begin
      sig_in    = sig_ff;
      step_in   = step_ff;
      hnn_in    = hnn_ff;
      cur_in    = cur_ff;
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      ec_in     = ec_ff;
      held_in   = held_ff;
      pan_in    = pan_ff;
      play_in   = play_ff;
      fifo_we   = 1'b0;
      fifo_wa   = wp_ff;
      fifo_wd   = cmd.data;
      left_in   = '0;
      right_in  = '0;
      base_rp   = rp_ff;
      base_wp   = wp_ff;
      wp_adv    = ptr_inc(wp_ff);
      smp       = held_ff;
      if (take) begin
         case (cmd.kind)
            apd_pkg::CMD_CONTROL: begin
               if (cmd.data[apd_pkg::CTRL_STOP]) begin
                  play_in = 1'b0;
               end else if (cmd.data[apd_pkg::CTRL_PLAY]) begin
                  if (!play_ff) begin
                     play_in = 1'b1;
                     sig_in  = -12'sd2;
                     fifo_we = 1'b1;
                     fifo_wa = '0;
                     rp_in   = '0;
                     wp_in   = apd_pkg::ptr_type'(1);
                     ec_in   = 8'd0;
                  end
                  step_in = 6'd0;
                  hnn_in  = 1'b0;
               end else begin
                  play_in = 1'b0;
               end
            end
            apd_pkg::CMD_DATA: begin
               if (ec_ff >= 8'd2) begin
                  base_rp = '0;
                  base_wp = '0;
               end
               wp_adv  = ptr_inc(base_wp);
               fifo_we = 1'b1;
               fifo_wa = base_wp;
               rp_in   = base_rp;
               wp_in   = (wp_adv == base_rp) ? base_wp : wp_adv;
               ec_in   = 8'd0;
            end
            apd_pkg::CMD_PAN: begin
               pan_in = cmd.data[1:0];
            end
            apd_pkg::CMD_TICK: begin
               if (play_ff && !cfg.mute) begin
                  cur_in = byte_v;
                  rp_in  = rp_v;
                  hnn_in = ~hnn_ff;
                  ec_in  = ec_v;
                  if (ec_v < 8'd2) begin
                     sig_in  = dec_sig;
                     held_in = {dec_sig, 4'd0};
                     if (st < 7'sd0) begin
                        step_in = 6'd0;
                     end else if (st > 7'(apd_pkg::STEP_MAX)) begin
                        step_in = 6'(apd_pkg::STEP_MAX);
                     end else begin
                        step_in = st[5:0];
                     end
                     smp = {dec_sig, 4'd0};
                  end else if (ec_v >= 8'd3) begin
                     ec_in   = ec_v - 8'd1;
                     sig_in  = pq[11:0];
                     held_in = {pq[11:0], 4'd0};
                     smp     = {pq[11:0], 4'd0};
                  end
                  left_in  = pan_ff[1] ? 16'sd0 : smp;
                  right_in = pan_ff[0] ? 16'sd0 : smp;
               end
            end
            default: begin
            end
         endcase
      end
      status_in = play_in ? 8'd0 : apd_pkg::IDLE_STATUS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff       <= -12'sd2;
         step_ff      <= 6'd0;
         hnn_ff       <= 1'b0;
         cur_ff       <= 8'd0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         ec_ff        <= 8'd255;
         held_ff      <= 16'sd0;
         pan_ff       <= 2'd0;
         play_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sig_ff  <= sig_in;
         step_ff <= step_in;
         hnn_ff  <= hnn_in;
         cur_ff  <= cur_in;
         rp_ff   <= rp_in;
         wp_ff   <= wp_in;
         ec_ff   <= ec_in;
         held_ff <= held_in;
         pan_ff  <= pan_in;
         play_ff <= play_in;
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_ff[fifo_wa] <= fifo_wd;
      end
      if (take) begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         status_ff <= status_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.left_sample  = left_ff;
   assign rsp.right_sample = right_ff;
   assign rsp.status_byte  = status_ff;

endmodule

/* rtl/core/adpcm_playback_device_unit.sv */
// ADPCM playback device: 4-bit adaptive differential decoder with byte FIFO.
// req_port carries one request per handshake: op 0 is a register write
// (reg_addr 0 control, 1 data FIFO, 2 pan, others ignored), op 1 is one
// sample tick. Every request yields exactly one response on rsp_port with
// left/right samples (zero for writes) and the status byte after it.
// csr_port writes mute, allow_10bit and output_12bit (index 0..2, data bit);
// it is always ready and must only be used while no request is in flight.
// Throughput: one request per cycle while rsp_port is ready. The front
// classifies each request into a two-entry queue; the back decodes one
// queued request per cycle through a combinational step ROM, leak multiply
// and clamp, then parks the response in an output register. With the queue
// empty, an accepted request passes through the queue and then the output
// register before response valid rises.
// When the receiver stalls, the response holds, the back freezes and the
// queue fills; req_port.ready drops once both queue slots are taken.
// Reset (synchronous, active high) stops playback, sets the signal level to
// minus two, the underrun counter to 255, and restores output_12bit to 1.
// The recording flag of the control register has no observable effect and
// is not kept.
module adpcm_playback_device_unit (
   input  logic      clock,
   input  logic      reset,
   apd_req_if.sink   req_port,
   apd_rsp_if.source rsp_port,
   apd_csr_if.sink   csr_port
);

   apd_pkg::cfg_type cfg_ff, cfg_in;
   logic             cmd_valid;
   logic             cmd_ready;
   apd_pkg::cmd_type cmd;

   // take a config write every cycle
   assign csr_port.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         case (csr_port.index)
            apd_pkg::REG_MUTE:         cfg_in.mute         = csr_port.data;
            apd_pkg::REG_ALLOW_10BIT:  cfg_in.allow_10bit  = csr_port.data;
            apd_pkg::REG_OUTPUT_12BIT: cfg_in.output_12bit = csr_port.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mute         <= 1'b0;
         cfg_ff.allow_10bit  <= 1'b0;
         cfg_ff.output_12bit <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify and queue requests
   apd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_port),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // execute and hold the response
   apd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp       (rsp_port)
   );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import apd_pkg::*;

   // Run length guard and settle time after the last response.
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_PAD   = 6;
   localparam int LONG_STALL  = 300;
   localparam int RESET_TICKS = 12;

   typedef struct {
      logic       op;
      logic [3:0] addr;
      logic [7:0] data;
   } playback_req_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [7:0]         status;
   } sample_type;

   logic clock;
   logic reset;

   apd_req_if req_bus ();
   apd_rsp_if rsp_bus ();
   apd_csr_if csr_bus ();

   adpcm_playback_device_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // Requests waiting for the driver, and the decoder outputs predicted for
   // every request the block has taken but not yet answered.
   playback_req_type pending_q[$];
   sample_type       expected_samples[$];

   // Idling controls: calm turns off random gaps on both sides, hold_go asks
   // the receiver for one long stall.
   bit calm;
   bit hold_go;
   bit hold_started;
   int stall_left;

   int cycle_count;
   int requests_taken;
   int responses_checked;
   int mismatches;
   int setting_writes;
   int decoded_nibbles;
   int decay_ticks;
   int clamp_hits;
   int fifo_full_hits;

   // ---------------------------------------------------------------------
   // Decoder prediction state
   // ---------------------------------------------------------------------
   bit         cfg_mute;
   bit         cfg_allow_10bit;
   bit         cfg_output_12bit;
   int         level;
   int         step_idx;
   bit         high_next;
   logic [7:0] cur_byte;
   logic [7:0] byte_fifo [FIFO_DEPTH];
   int         rd_ptr;
   int         wr_ptr;
   int         dry_count;
   int         held;
   logic [1:0] pan;
   bit         playing;
   int         step_table [0:STEP_MAX];

   task automatic clear_decoder();
      cfg_mute         = 1'b0;
      cfg_allow_10bit  = 1'b0;
      cfg_output_12bit = 1'b1;
      level            = -2;
      step_idx         = 0;
      high_next        = 1'b0;
      cur_byte         = 8'h00;
      rd_ptr           = 0;
      wr_ptr           = 0;
      dry_count        = 255;
      held             = 0;
      pan              = 2'b00;
      playing          = 1'b0;
      // step sizes floor(16 * 1.1^n)
      step_table = '{16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41, 45, 50, 55, 60, 66,
                     73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190, 209, 230,
                     253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658, 724,
                     796, 876, 963, 1060, 1166, 1282, 1411, 1552};
   endtask

   // Decode one nibble: scaled step difference, leaky integrate, clamp,
   // then move the step index.
   function automatic int decode_nibble(logic [3:0] nib);
      int bound;
      int sz;
      int diff;
      int acc;
      bound = (cfg_allow_10bit && !cfg_output_12bit) ? 512 : 2048;
      sz    = step_table[step_idx];
      diff  = sz / 8;
      if (nib[2]) diff += sz;
      if (nib[1]) diff += sz / 2;
      if (nib[0]) diff += sz / 4;
      if (nib[3]) diff = -diff;
      acc   = diff * 256 + level * LEAK_NUM;
      level = acc >>> 8;
      if (level > bound - 1) begin
         level = bound - 1;
         clamp_hits++;
      end else if (level < -bound) begin
         level = -bound;
         clamp_hits++;
      end
      if (nib[2:0] >= 3'd4) step_idx += 2 * (int'(nib[2:0]) - 3);
      else step_idx -= 1;
      if (step_idx > STEP_MAX) step_idx = STEP_MAX;
      else if (step_idx < 0) step_idx = 0;
      decoded_nibbles++;
      return level * 16;
   endfunction

   function automatic int sample_tick();
      int         s;
      logic [3:0] nib;
      if (!high_next) begin
         if (dry_count == 0) begin
            cur_byte = byte_fifo[rd_ptr];
            rd_ptr   = (rd_ptr + 1) % FIFO_DEPTH;
            if (rd_ptr == wr_ptr) dry_count++;
         end else if (dry_count < 128) begin
            dry_count++;
         end
      end
      nib = high_next ? cur_byte[7:4] : cur_byte[3:0];
      if (dry_count < 2) begin
         s    = decode_nibble(nib);
         held = s;
      end else begin
         // underrun: decay toward zero and hold the last sample
         if (dry_count >= 3) begin
            dry_count--;
            level = (level * 15) / 16;
            held  = level * 16;
            decay_ticks++;
         end
         s = held;
      end
      high_next = !high_next;
      return s;
   endfunction

   function automatic void control_write(logic [7:0] d);
      if (d[CTRL_STOP]) begin
         playing = 1'b0;
      end else if (d[CTRL_PLAY]) begin
         if (!playing) begin
            playing      = 1'b1;
            level        = -2;
            byte_fifo[0] = d;
            rd_ptr       = 0;
            wr_ptr       = 1;
            dry_count    = 0;
         end
         step_idx  = 0;
         high_next = 1'b0;
      end else begin
         playing = 1'b0;
      end
   endfunction

   function automatic void data_write(logic [7:0] d);
      if (dry_count >= 2) begin
         rd_ptr = 0;
         wr_ptr = 0;
      end
      byte_fifo[wr_ptr] = d;
      wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
      if (wr_ptr == rd_ptr) begin
         wr_ptr = (wr_ptr + FIFO_DEPTH - 1) % FIFO_DEPTH;
         fifo_full_hits++;
      end
      dry_count = 0;
   endfunction

   // Work out the response to one accepted request and queue it.
   function automatic void predict_samples(logic op, logic [3:0] addr, logic [7:0] d);
      sample_type e;
      int         s;
      e = '0;
      if (op == OP_WRITE) begin
         case (addr)
            ADDR_CONTROL: control_write(d);
            ADDR_DATA:    data_write(d);
            ADDR_PAN:     pan = d[1:0];
            default:      ;
         endcase
      end else if (playing && !cfg_mute) begin
         s = sample_tick();
         e.left  = pan[1] ? 16'sd0 : s[15:0];
         e.right = pan[0] ? 16'sd0 : s[15:0];
      end
      e.status = playing ? 8'h00 : IDLE_STATUS;
      expected_samples.push_back(e);
   endfunction

   // ---------------------------------------------------------------------
   // Clock and run-length guard
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still expected",
                  cycle_count, expected_samples.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request driver: predict on every accepted request, then offer the next
   // pending one unless this cycle is picked as a gap.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      playback_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_samples(req_bus.op, req_bus.reg_addr, req_bus.write_data);
            requests_taken++;
         end
         // advance only when the current request is gone or none is shown
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
               nxt = pending_q.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.op         <= nxt.op;
               req_bus.reg_addr   <= nxt.addr;
               req_bus.write_data <= nxt.data;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, plus one long hold-off on request
   // so that the block's queue fills and its input stalls.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
         hold_started  <= 1'b0;
      end else if (hold_go && !hold_started) begin
         hold_started  <= 1'b1;
         stall_left    <= LONG_STALL;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= 25);
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin : response_monitor
      sample_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response with no request outstanding: L=%0d R=%0d st=%0h",
                        rsp_bus.left_sample, rsp_bus.right_sample, rsp_bus.status_byte);
         end else begin
            e = expected_samples.pop_front();
            if (rsp_bus.left_sample !== e.left || rsp_bus.right_sample !== e.right ||
                rsp_bus.status_byte !== e.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d: expected L=%0d R=%0d st=%0h, got L=%0d R=%0d st=%0h",
                           responses_checked, e.left, e.right, e.status,
                           rsp_bus.left_sample, rsp_bus.right_sample,
                           rsp_bus.status_byte);
            end
            responses_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic add_request(logic op, logic [3:0] addr, logic [7:0] d);
      playback_req_type r;
      r.op   = op;
      r.addr = addr;
      r.data = d;
      pending_q.push_back(r);
   endtask

   // Hold until every pending request is taken and answered, then let the
   // block's pipeline empty out.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_q.size() != 0 || req_bus.valid || expected_samples.size() != 0)
         @(negedge clock);
      repeat (DRAIN_PAD) @(negedge clock);
   endtask

   task automatic write_setting(logic [1:0] idx, logic val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         REG_MUTE:         cfg_mute = val;
         REG_ALLOW_10BIT:  cfg_allow_10bit = val;
         REG_OUTPUT_12BIT: cfg_output_12bit = val;
         default:          ;
      endcase
      setting_writes++;
      @(negedge clock);
   endtask

   // Queue about n useful requests: mostly play sessions (start, then a mix
   // of data bytes and ticks), with short bursts of pure noise in between.
   // Writes to unused addresses within a session do not count toward n.
   task automatic queue_sessions(int n);
      int         made;
      int         len;
      int         tick_pct;
      bit         loud;
      int         k;
      logic [7:0] d;
      made = 0;
      while (made < n) begin
         if ($urandom_range(99) < 10) begin
            len = $urandom_range(8, 3);
            repeat (len) begin
               add_request(1'($urandom_range(1)), 4'($urandom_range(15)),
                           8'($urandom_range(255)));
               made++;
            end
         end else begin
            // start play with random upper bits; the byte also seeds the FIFO
            d = (8'($urandom_range(255)) & 8'hFE) | 8'h02;
            add_request(OP_WRITE, ADDR_CONTROL, d);
            made++;
            len      = $urandom_range(60, 8);
            tick_pct = $urandom_range(80, 30);
            loud     = ($urandom_range(3) == 0);
            repeat (len) begin
               if ($urandom_range(99) < tick_pct) begin
                  add_request(OP_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
                  made++;
               end else begin
                  k = $urandom_range(99);
                  if (k < 75) begin
                     // loud bytes push the step index up and drive clamping
                     d = loud ? ((8'($urandom_range(255)) & 8'h99) | 8'h66)
                              : 8'($urandom_range(255));
                     add_request(OP_WRITE, ADDR_DATA, d);
                     made++;
                  end else if (k < 83) begin
                     add_request(OP_WRITE, ADDR_PAN, 8'($urandom_range(255)));
                     made++;
                  end else if (k < 90) begin
                     add_request(OP_WRITE, 4'($urandom_range(15, 3)),
                                 8'($urandom_range(255)));
                  end else if (k < 96) begin
                     d = (8'($urandom_range(255)) & 8'hFE) | 8'h02;
                     add_request(OP_WRITE, ADDR_CONTROL, d);
                     made++;
                  end else begin
                     // may stop play mid-session
                     add_request(OP_WRITE, ADDR_CONTROL, 8'($urandom_range(255)));
                     made++;
                  end
               end
            end
         end
      end
   endtask

   initial begin
      clear_decoder();
      calm               = 1'b0;
      hold_go            = 1'b0;
      cycle_count        = 0;
      requests_taken     = 0;
      responses_checked  = 0;
      mismatches         = 0;
      setting_writes     = 0;
      decoded_nibbles    = 0;
      decay_ticks        = 0;
      clamp_hits         = 0;
      fifo_full_hits     = 0;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_WRITE;
      req_bus.reg_addr   = ADDR_CONTROL;
      req_bus.write_data = 8'h00;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_MUTE;
      csr_bus.data       = 1'b0;
      reset              = 1'b1;
      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: idle tick, write while idle, play with record, pan gating,
      // unused addresses, restart while playing, underrun decay, stop.
      add_request(OP_TICK,  4'hF,         8'hFF);
      add_request(OP_WRITE, ADDR_DATA,    8'h00);
      add_request(OP_WRITE, ADDR_CONTROL, 8'h06);
      add_request(OP_WRITE, ADDR_DATA,    8'h77);
      add_request(OP_WRITE, ADDR_DATA,    8'hFF);
      add_request(OP_TICK,  4'h0,         8'h00);
      add_request(OP_TICK,  4'h0,         8'h00);
      add_request(OP_TICK,  4'h0,         8'h00);
      add_request(OP_WRITE, ADDR_PAN,     8'h02);
      add_request(OP_TICK,  4'h5,         8'hA5);
      add_request(OP_WRITE, ADDR_PAN,     8'h01);
      add_request(OP_TICK,  4'hA,         8'h5A);
      add_request(OP_WRITE, ADDR_PAN,     8'hFF);
      add_request(OP_TICK,  4'h0,         8'h00);
      add_request(OP_WRITE, ADDR_PAN,     8'h00);
      add_request(OP_WRITE, 4'hF,         8'hAA);
      add_request(OP_WRITE, 4'h3,         8'h55);
      add_request(OP_WRITE, ADDR_CONTROL, 8'hFE);
      repeat (4) add_request(OP_TICK, 4'h0, 8'h00);
      add_request(OP_WRITE, ADDR_CONTROL, 8'h01);
      add_request(OP_TICK,  4'h0,         8'h00);
      add_request(OP_WRITE, ADDR_CONTROL, 8'h00);
      wait_drained();

      // Phase with no idling on either side, reset settings.
      calm = 1'b1;
      queue_sessions(220);
      wait_drained();
      calm = 1'b0;

      // Narrow clamp; stall the receiver while requests keep coming.
      write_setting(REG_ALLOW_10BIT, 1'b1);
      write_setting(REG_OUTPUT_12BIT, 1'b0);
      queue_sessions(220);
      repeat (40) @(negedge clock);
      hold_go = 1'b1;
      wait_drained();

      // Wide clamp again; drop input until all responses are back mid-way.
      write_setting(REG_OUTPUT_12BIT, 1'b1);
      queue_sessions(110);
      wait_drained();
      queue_sessions(110);
      wait_drained();

      // Muted: ticks must return zero and freeze the decoder.
      write_setting(REG_MUTE, 1'b1);
      queue_sessions(100);
      wait_drained();

      write_setting(REG_MUTE, 1'b0);
      write_setting(REG_ALLOW_10BIT, 1'b0);
      write_setting(REG_OUTPUT_12BIT, 1'b0);
      queue_sessions(220);
      wait_drained();

      write_setting(REG_ALLOW_10BIT, 1'b1);
      queue_sessions(220);
      wait_drained();

      if (expected_samples.size() != 0) begin
         $display("%0d responses never arrived", expected_samples.size());
         mismatches += expected_samples.size();
      end
      $display("covered %0d requests: %0d nibbles decoded, %0d decay ticks, %0d clamps",
               requests_taken, decoded_nibbles, decay_ticks, clamp_hits);
      $display("%0d FIFO-full writes, %0d setting writes, %0d responses checked, %0d bad",
               fifo_full_hits, setting_writes, responses_checked, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/apd_pkg.sv
rtl/core/apd_if.sv
rtl/core/apd_front.sv
rtl/core/apd_back.sv
rtl/core/adpcm_playback_device_unit.sv
tb/sv/tb_top.sv
